### sv/alignment_compartment_exon_scorer_top_assert.svh
// Assertion macros shared by the exon scorer RTL files.
// Each macro expects clk_i and rst_ni to be visible in the module that uses it.
`ifndef ALIGNMENT_COMPARTMENT_EXON_SCORER_TOP_ASSERT_SVH
`define ALIGNMENT_COMPARTMENT_EXON_SCORER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACES_ASSERT_HOLDS(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACES_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/aces_pkg.sv
// Package for the alignment compartment exon scorer.
// Holds widths, register indexes and the payload types used by all RTL files.
`default_nettype none

package aces_pkg;

  // Field widths.
  localparam int CoordW        = 32;
  localparam int LenW          = 32;
  localparam int IdentW        = 17;
  localparam int IdentFracBits = 16;
  localparam int ExonW         = 16;
  localparam int MatchW        = 32;
  localparam int BinW          = 4;
  localparam int CfgW          = 16;
  localparam int CfgIdxW       = 2;

  // Internal widths.
  localparam int SumW  = 64;
  localparam int OpW   = (CoordW > LenW) ? CoordW : LenW;
  localparam int ProdW = OpW + IdentW;
  // Ten times a saturated match count fits in BinW more bits.
  localparam int NumW  = MatchW + BinW;
  localparam int StepW = $clog2(BinW);

  // Queue between the front and the back.
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // Register indexes.
  localparam logic [CfgIdxW-1:0] CfgMinExon   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgMinIntron = CfgIdxW'(1);

  // Register reset values.
  localparam logic [CfgW-1:0] MinExonReset   = CfgW'(10);
  localparam logic [CfgW-1:0] MinIntronReset = CfgW'(25);

  localparam logic [ExonW-1:0] ExonMax = '1;
  localparam logic [BinW-1:0]  BinMax  = '1;

  typedef struct packed {
    logic [CoordW-1:0] query_start;
    logic [CoordW-1:0] query_stop;
    logic [CoordW-1:0] subj_start;
    logic [CoordW-1:0] subj_stop;
    logic [LenW-1:0]   hit_length;
    logic [IdentW-1:0] identity;
    logic              plus_strand;
    logic [LenW-1:0]   query_length;
    logic              last_hit;
  } hit_t;

  typedef struct packed {
    logic [ExonW-1:0]  exon_count;
    logic [MatchW-1:0] match_count;
    logic [BinW-1:0]   identity_bin;
  } score_t;

  typedef struct packed {
    logic [CfgW-1:0] min_exon_length;
    logic [CfgW-1:0] min_intron_length;
  } cfg_t;

  // One closed compartment on its way to the back.
  typedef struct packed {
    logic [ExonW-1:0] exon_count;
    logic [SumW-1:0]  match_sum;
    logic [LenW-1:0]  query_length;
  } entry_t;

  // Queue handshake seen from one side.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROUND,
    BK_SCALE,
    BK_CHECK,
    BK_DIV,
    BK_DONE
  } back_state_e;

endpackage

`default_nettype wire

### sv/alignment_compartment_exon_scorer_top.sv
// Top level of the alignment compartment exon scorer: configuration registers,
// front, queue and back. Depends on aces_pkg, aces_front, aces_fifo, aces_back.
//
//   channel   direction  handshake         payload
//   hits      in         push / full       hit_i (hit_t)
//   scores    out        empty / pop       score_o (score_t)
//   config    in         cfg_we_i          cfg_idx_i, cfg_data_i
//
// The front takes one hit per cycle when not held; a hit passes three register
// stages (capture, operand, multiply) before its product is summed.
// A closing hit enters the two-entry queue; the back works on one compartment at a time
// (rounding, scaling by ten, one quotient bit per cycle over four).
// The front holds (full high) only when a closing hit meets a full queue.
// Reset clears all control state and sets the exon tally to one; no clearing pass.
`default_nettype none

module alignment_compartment_exon_scorer_top import aces_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  hit_t               hit_i,
  input  logic               push,
  output logic               full,
  output score_t             score_o,
  output logic               empty,
  input  logic               pop
);

  cfg_t         cfg_q;
  fifo_status_t fifo_st;
  logic         fifo_push;
  logic         fifo_pop;
  entry_t       fifo_wdata;
  entry_t       fifo_rdata;
  logic         push_ok;
  logic         pop_ok;

  // Configuration register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_exon_length   <= MinExonReset;
      cfg_q.min_intron_length <= MinIntronReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMinExon:   cfg_q.min_exon_length   <= cfg_data_i;
        CfgMinIntron: cfg_q.min_intron_length <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Qualified transactions on the two queue-like sides.
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;

  aces_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .hit_i       (hit_i),
    .push        (push_ok),
    .full        (full),
    .fifo_i      (fifo_st),
    .fifo_push_o (fifo_push),
    .fifo_data_o (fifo_wdata)
  );

  aces_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (fifo_wdata),
    .pop_i   (fifo_pop),
    .data_o  (fifo_rdata),
    .full_o  (fifo_st.full),
    .empty_o (fifo_st.empty)
  );

  aces_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_i      (fifo_st),
    .fifo_data_i (fifo_rdata),
    .fifo_pop_o  (fifo_pop),
    .score_o     (score_o),
    .empty       (empty),
    .pop         (pop_ok)
  );

endmodule

`default_nettype wire

### sv/aces_fifo.sv
// Short register queue carrying closed compartments from the front to the back.
// Depends on aces_pkg for the entry type and the queue depth.
`default_nettype none
`include "alignment_compartment_exon_scorer_top_assert.svh"

module aces_fifo import aces_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  input  logic   pop_i,
  output entry_t data_o,
  output logic   full_o,
  output logic   empty_o
);

  entry_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage, no reset needed.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `ACES_ASSERT_HOLDS(a_push_has_room, push_i, !full_o, "push into a full queue")
  `ACES_ASSERT_HOLDS(a_pop_has_data, pop_i, !empty_o, "pop from an empty queue")

endmodule

`default_nettype wire

### sv/aces_front.sv
// Front of the exon scorer: takes hits, updates the compartment state and
// accumulates the weighted match sum. Depends on aces_pkg.
`default_nettype none
`include "alignment_compartment_exon_scorer_top_assert.svh"

module aces_front import aces_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  hit_t         hit_i,
  input  logic         push,
  output logic         full,
  input  fifo_status_t fifo_i,
  output logic         fifo_push_o,
  output entry_t       fifo_data_o
);

  // Stage 1: captured hit.
  hit_t s1_q;
  logic s1_v_q;

  // Stage 2: multiplier operands.
  logic              s2_v_q;
  logic [OpW-1:0]    s2_op_q, s2_op_d;
  logic [IdentW-1:0] s2_ident_q;
  logic              s2_last_q;
  logic [ExonW-1:0]  s2_exon_q, s2_exon_d;
  logic [LenW-1:0]   s2_qlen_q;

  // Stage 3: product.
  logic             s3_v_q;
  logic [ProdW-1:0] s3_prod_q;
  logic             s3_last_q;
  logic [ExonW-1:0] s3_exon_q;
  logic [LenW-1:0]  s3_qlen_q;

  // Compartment state.
  logic              have_prev_q, have_prev_d;
  logic [CoordW-1:0] prev_qstop_q, prev_qstop_d;
  logic [CoordW-1:0] prev_sstop_q, prev_sstop_d;
  logic              strand_q, strand_d;
  logic [ExonW-1:0]  exon_q, exon_d;
  logic [SumW-1:0]   sum_q, sum_d;

  logic              en;
  logic              advance_ok;
  logic              new_exon;
  logic [CoordW+1:0] gap_lhs, gap_rhs;
  logic [CoordW-1:0] q0max;
  logic [SumW:0]     sum_ext;
  logic [SumW-1:0]   sum_new;

  // The whole pipeline holds only when a closing hit meets a full queue.
  assign en   = !(s3_v_q && s3_last_q && fifo_i.full);
  assign full = !en;

  // Query advance, subject gap and match operand for the hit in stage 1.
  always_comb begin
    advance_ok = ({1'b0, prev_qstop_q} + (CoordW+1)'(cfg_i.min_exon_length))
                 <= {1'b0, s1_q.query_stop};
    if (strand_q) begin
      gap_lhs = (CoordW+2)'(prev_sstop_q) + (CoordW+2)'(cfg_i.min_intron_length)
                + (CoordW+2)'(s1_q.query_start);
      gap_rhs = (CoordW+2)'(s1_q.subj_start) + (CoordW+2)'(prev_qstop_q);
    end else begin
      gap_lhs = (CoordW+2)'(s1_q.subj_start) + (CoordW+2)'(s1_q.query_start)
                + (CoordW+2)'(cfg_i.min_intron_length);
      gap_rhs = (CoordW+2)'(prev_sstop_q) + (CoordW+2)'(prev_qstop_q);
    end
    new_exon = (gap_lhs <= gap_rhs);
    q0max = (prev_qstop_q > s1_q.query_start) ? prev_qstop_q : s1_q.query_start;

    have_prev_d  = have_prev_q;
    strand_d     = strand_q;
    exon_d       = exon_q;
    s2_op_d      = '0;
    if (!have_prev_q) begin
      strand_d    = s1_q.plus_strand;
      exon_d      = ExonW'(1);
      s2_op_d     = OpW'(s1_q.hit_length);
      have_prev_d = 1'b1;
    end else if (advance_ok) begin
      if (new_exon && (exon_q != ExonMax)) begin
        exon_d = exon_q + 1'b1;
      end
      if (s1_q.query_stop > q0max) begin
        s2_op_d = OpW'(s1_q.query_stop - q0max);
      end
    end
    prev_qstop_d = s1_q.query_stop;
    prev_sstop_d = s1_q.subj_stop;
    s2_exon_d    = exon_d;

    // A closing hit resets the compartment.
    if (s1_q.last_hit) begin
      have_prev_d  = 1'b0;
      prev_qstop_d = '0;
      prev_sstop_d = '0;
      strand_d     = 1'b0;
      exon_d       = ExonW'(1);
    end
  end

  // Saturating accumulate of the product in stage 3.
  always_comb begin
    sum_ext = {1'b0, sum_q} + (SumW+1)'(s3_prod_q);
    sum_new = sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
    sum_d   = s3_last_q ? '0 : sum_new;
  end

  assign fifo_push_o              = en && s3_v_q && s3_last_q;
  assign fifo_data_o.exon_count   = s3_exon_q;
  assign fifo_data_o.match_sum    = sum_new;
  assign fifo_data_o.query_length = s3_qlen_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
      s3_v_q       <= 1'b0;
      have_prev_q  <= 1'b0;
      prev_qstop_q <= '0;
      prev_sstop_q <= '0;
      strand_q     <= 1'b0;
      exon_q       <= ExonW'(1);
      sum_q        <= '0;
    end else if (en) begin
      s1_v_q <= push;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      if (s1_v_q) begin
        have_prev_q  <= have_prev_d;
        prev_qstop_q <= prev_qstop_d;
        prev_sstop_q <= prev_sstop_d;
        strand_q     <= strand_d;
        exon_q       <= exon_d;
      end
      if (s3_v_q) begin
        sum_q <= sum_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (push) begin
        s1_q <= hit_i;
      end
      s2_op_q    <= s2_op_d;
      s2_ident_q <= s1_q.identity;
      s2_last_q  <= s1_v_q && s1_q.last_hit;
      s2_exon_q  <= s2_exon_d;
      s2_qlen_q  <= s1_q.query_length;
      s3_prod_q  <= ProdW'(s2_op_q) * ProdW'(s2_ident_q);
      s3_last_q  <= s2_v_q && s2_last_q;
      s3_exon_q  <= s2_exon_q;
      s3_qlen_q  <= s2_qlen_q;
    end
  end

  `ACES_ASSERT_HOLDS(a_exon_nonzero, 1'b1, exon_q != '0, "exon tally reached zero")
  `ACES_ASSERT_NEXT(a_close_clears, en && s1_v_q && s1_q.last_hit, !have_prev_q,
                    "closing hit did not clear the compartment")

endmodule

`default_nettype wire

### sv/aces_back.sv
// Back of the exon scorer: rounds the match sum, scales it by ten and divides by
// the query length one quotient bit per cycle. Depends on aces_pkg.
`default_nettype none
`include "alignment_compartment_exon_scorer_top_assert.svh"

module aces_back import aces_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  fifo_status_t fifo_i,
  input  entry_t       fifo_data_i,
  output logic         fifo_pop_o,
  output score_t       score_o,
  output logic         empty,
  input  logic         pop
);

  back_state_e state_q, state_d;

  entry_t            ent_q;
  logic [MatchW-1:0] rnd_q;
  logic [NumW-1:0]   rem_q;
  logic [BinW-1:0]   quo_q;
  logic [StepW-1:0]  step_q;
  score_t            out_q;
  logic              out_v_q;

  logic                        out_load;
  logic [SumW-IdentFracBits:0] rnd_ext;
  logic [MatchW-1:0]           rnd_sat;
  logic [NumW-1:0]             num_x10;
  logic [NumW-1:0]             qlen_ext;
  logic [NumW-1:0]             trial;
  logic [NumW-1:0]             div_bound;
  logic                        saturate;

  // Datapath helpers.
  always_comb begin
    rnd_ext  = (SumW-IdentFracBits+1)'(ent_q.match_sum[SumW-1:IdentFracBits])
               + (SumW-IdentFracBits+1)'(ent_q.match_sum[IdentFracBits-1]);
    rnd_sat  = (rnd_ext[SumW-IdentFracBits:MatchW] != '0) ? '1 : rnd_ext[MatchW-1:0];
    num_x10  = (NumW'(rnd_q) << 3) + (NumW'(rnd_q) << 1);
    qlen_ext = NumW'(ent_q.query_length);
    trial    = qlen_ext << step_q;
    div_bound = qlen_ext << ({1'b0, step_q} + 1'b1);
    saturate = (ent_q.query_length == '0) || (rem_q >= (qlen_ext << BinW));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (!fifo_i.empty) state_d = BK_ROUND;
      BK_ROUND: state_d = BK_SCALE;
      BK_SCALE: state_d = BK_CHECK;
      BK_CHECK: state_d = saturate ? BK_DONE : BK_DIV;
      BK_DIV:   if (step_q == '0) state_d = BK_DONE;
      BK_DONE:  if (!out_v_q || pop) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    fifo_pop_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      BK_IDLE: fifo_pop_o = !fifo_i.empty;
      BK_DONE: out_load   = !out_v_q || pop;
      default: begin
        fifo_pop_o = 1'b0;
        out_load   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (pop) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Rounding, scaling and restoring division.
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        ent_q <= fifo_data_i;
      end
      BK_ROUND: begin
        rnd_q <= rnd_sat;
      end
      BK_SCALE: begin
        rem_q <= num_x10;
      end
      BK_CHECK: begin
        quo_q  <= saturate ? BinMax : '0;
        step_q <= StepW'(BinW - 1);
      end
      BK_DIV: begin
        if (rem_q >= trial) begin
          rem_q         <= rem_q - trial;
          quo_q[step_q] <= 1'b1;
        end
        step_q <= step_q - 1'b1;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_q.exon_count   <= ent_q.exon_count;
      out_q.match_count  <= rnd_q;
      out_q.identity_bin <= quo_q;
    end
  end

  assign score_o = out_q;
  assign empty   = !out_v_q;

  `ACES_ASSERT_HOLDS(a_div_remainder, state_q == BK_DIV, rem_q < div_bound,
                     "division remainder out of range")

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for the alignment compartment exon scorer top level.
// Depends on aces_pkg and the RTL below alignment_compartment_exon_scorer_top.
`timescale 1ns / 100ps

module tb_top;
  import aces_pkg::*;

  // Register indexes that no register answers to.
  localparam logic [CfgIdxW-1:0] CfgUnusedA = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgUnusedB = CfgIdxW'(3);

  localparam logic [IdentW-1:0] IdentOne  = IdentW'(65536);
  localparam logic [IdentW-1:0] IdentHalf = IdentW'(32768);
  localparam int BinScale     = 10;
  localparam int DrainCycles  = 40;
  localparam int RandomPhases = 8;
  localparam int PhaseItems   = 240;
  localparam int CycleLimit   = 500000;
  localparam int MaxReports   = 100;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;
  hit_t               hit_i;
  logic               push;
  logic               full;
  score_t             score_o;
  logic               empty;
  logic               pop;

  // Scoring model state and register copies.
  logic              cmp_open;
  logic [CoordW-1:0] last_qstop;
  logic [CoordW-1:0] last_sstop;
  logic              cmp_plus;
  logic [ExonW-1:0]  exon_tally;
  logic [SumW-1:0]   match_acc;
  logic [CfgW-1:0]   cfg_min_exon;
  logic [CfgW-1:0]   cfg_min_intron;

  score_t expected_scores[$];
  int     mismatch_count = 0;
  int     hits_sent      = 0;
  int     cycle_count    = 0;
  bit     send_no_idle   = 1'b0;
  bit     sink_no_idle   = 1'b0;

  alignment_compartment_exon_scorer_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .hit_i      (hit_i),
    .push       (push),
    .full       (full),
    .score_o    (score_o),
    .empty      (empty),
    .pop        (pop)
  );

  // Free-running clock.
  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReports) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Coordinates are compared as exact signed values, never wrapped.
  function automatic longint as_signed(input logic [CoordW-1:0] v);
    return longint'({{(64-CoordW){1'b0}}, v});
  endfunction

  task automatic clear_compartment();
    cmp_open   = 1'b0;
    last_qstop = '0;
    last_sstop = '0;
    cmp_plus   = 1'b0;
    exon_tally = ExonW'(1);
    match_acc  = '0;
  endtask

  // Update the compartment model with one accepted hit; a closing hit queues its score.
  task automatic score_hit(input hit_t h);
    logic [CoordW-1:0] q_from;
    logic [SumW-1:0]   term;
    logic [SumW:0]     total;
    logic [SumW-1:0]   rounded;
    logic [SumW-1:0]   bin;
    longint            s_implied;
    bit                new_exon;
    score_t            sc;
    // Products are at most 49 bits wide, so only the sum can saturate.
    if (!cmp_open) begin
      cmp_plus   = h.plus_strand;
      exon_tally = ExonW'(1);
      match_acc  = SumW'(h.hit_length) * SumW'(h.identity);
      cmp_open   = 1'b1;
    end else if (SumW'(last_qstop) + SumW'(cfg_min_exon) <= SumW'(h.query_stop)) begin
      q_from = (last_qstop > h.query_start) ? last_qstop : h.query_start;
      if (cmp_plus) begin
        s_implied = as_signed(h.subj_start) -
                    (as_signed(h.query_start) - as_signed(last_qstop));
        new_exon  = as_signed(last_sstop) + as_signed(CoordW'(cfg_min_intron)) <= s_implied;
      end else begin
        s_implied = as_signed(h.subj_start) + as_signed(h.query_start) -
                    as_signed(last_qstop);
        new_exon  = s_implied + as_signed(CoordW'(cfg_min_intron)) <= as_signed(last_sstop);
      end
      if (new_exon && exon_tally < ExonMax) exon_tally++;
      if (h.query_stop > q_from) begin
        term      = SumW'(h.query_stop - q_from) * SumW'(h.identity);
        total     = {1'b0, match_acc} + {1'b0, term};
        match_acc = total[SumW] ? '1 : total[SumW-1:0];
      end
    end
    last_qstop = h.query_stop;
    last_sstop = h.subj_stop;

    if (h.last_hit) begin
      // Round half up, then saturate to the match field.
      rounded = (match_acc >> IdentFracBits) + SumW'(match_acc[IdentFracBits-1]);
      if (rounded > SumW'({MatchW{1'b1}})) rounded = SumW'({MatchW{1'b1}});
      if (h.query_length == '0) bin = SumW'(BinMax);
      else bin = (rounded * BinScale) / SumW'(h.query_length);
      if (bin > SumW'(BinMax)) bin = SumW'(BinMax);
      sc.exon_count   = exon_tally;
      sc.match_count  = rounded[MatchW-1:0];
      sc.identity_bin = bin[BinW-1:0];
      expected_scores.insert(expected_scores.size(), sc);
      clear_compartment();
    end
  endtask

  // Offer one hit after a random gap and hold it until the block takes it.
  task automatic send_hit(input hit_t h);
    int gap;
    if ($urandom_range(0, 39) == 0) send_no_idle = ~send_no_idle;
    gap = send_no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push  <= 1'b1;
    hit_i <= h;
    do @(posedge clk_i); while (full);
    hits_sent++;
    score_hit(h);
  endtask

  // Stop offering hits and wait until every score is out and the block is quiet.
  task automatic drain_scores();
    push <= 1'b0;
    wait (expected_scores.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CfgMinExon:   cfg_min_exon   = value;
      CfgMinIntron: cfg_min_intron = value;
      default: ;
    endcase
  endtask

  function automatic hit_t make_hit(input logic [CoordW-1:0] qs, qe, ss, se,
                                    input logic [LenW-1:0]   hlen,
                                    input logic [IdentW-1:0] ident,
                                    input logic              plus,
                                    input logic [LenW-1:0]   qlen,
                                    input logic              closing);
    hit_t h;
    h.query_start  = qs;
    h.query_stop   = qe;
    h.subj_start   = ss;
    h.subj_stop    = se;
    h.hit_length   = hlen;
    h.identity     = ident;
    h.plus_strand  = plus;
    h.query_length = qlen;
    h.last_hit     = closing;
    return h;
  endfunction

  function automatic hit_t noise_hit(input bit closing);
    hit_t h;
    h.query_start  = $urandom();
    h.query_stop   = $urandom();
    h.subj_start   = $urandom();
    h.subj_stop    = $urandom();
    h.hit_length   = $urandom();
    h.identity     = IdentW'($urandom_range(0, 131071));
    h.plus_strand  = 1'($urandom_range(0, 1));
    h.query_length = $urandom();
    h.last_hit     = closing || ($urandom_range(0, 2) == 0);
    return h;
  endfunction

  // One well-formed compartment with random content near the thresholds.
  task automatic send_compartment();
    hit_t        h;
    int          n_hits;
    int          adv;
    int          lead;
    int          gap_delta;
    int          pick;
    bit          plus;
    logic [31:0] q_prev;
    logic [31:0] s_prev;
    longint      span;
    longint      q_lo;
    longint      q_hi;
    h      = '0;
    n_hits = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
    plus   = 1'($urandom_range(0, 1));
    q_prev = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 100000);
    s_prev = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 100000);
    span   = 0;
    for (int i = 0; i < n_hits; i++) begin
      // Query advance mostly straddles the exon threshold.
      adv = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 40))
                                         : int'(cfg_min_exon) + int'($urandom_range(0, 300)) - 3;
      lead      = int'($urandom_range(0, 30)) - 15;
      gap_delta = int'(cfg_min_intron) + int'($urandom_range(0, 40)) - 20;
      h.query_start = q_prev + 32'(lead);
      h.query_stop  = q_prev + 32'(adv);
      // Subject start placed so the implied gap sits near the intron threshold.
      if (plus) h.subj_start = s_prev + 32'(gap_delta) + (h.query_start - q_prev);
      else h.subj_start = s_prev - 32'(gap_delta) - (h.query_start - q_prev);
      h.subj_stop  = plus ? h.subj_start + 32'(adv) : h.subj_start - 32'(adv);
      h.hit_length = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 400);
      pick = $urandom_range(0, 9);
      if (pick == 0) h.identity = IdentW'($urandom_range(0, 131071));
      else if (pick < 4) h.identity = IdentW'($urandom_range(0, 65536));
      else h.identity = IdentW'($urandom_range(45000, 65536));
      h.plus_strand = (i == 0 || $urandom_range(0, 9) != 0) ? plus : ~plus;
      h.last_hit    = (i == n_hits - 1);
      if (i == 0) span = longint'(h.hit_length);
      else if (adv > 0) span += longint'(adv);
      // Query length chosen so the identity bin spreads over its range.
      if (!h.last_hit) h.query_length = $urandom();
      else if ($urandom_range(0, 63) == 0) h.query_length = '0;
      else if ($urandom_range(0, 7) == 0) h.query_length = $urandom();
      else begin
        q_hi = 2 * span + 2;
        if (q_hi > 64'hFFFF_FFFF) q_hi = 64'hFFFF_FFFF;
        q_lo = span / 2 + 1;
        if (q_lo > q_hi) q_lo = q_hi;
        h.query_length = $urandom_range(32'(q_hi), 32'(q_lo));
      end
      send_hit(h);
      q_prev = h.query_stop;
      s_prev = h.subj_stop;
    end
  endtask

  // Single-hit compartments at the field extremes, including a zero query length.
  task automatic test_single_hit_extremes();
    send_hit(make_hit('1, '1, '1, '1, '1, IdentOne, 1'b1, '1, 1'b1));
    send_hit(make_hit('0, '0, '0, '0, '1, '1, 1'b0, LenW'(1), 1'b1));
    send_hit(make_hit('0, '0, '0, '0, '0, '0, 1'b1, '0, 1'b1));
    drain_scores();
  endtask

  // Rounding of the match sum at and around one half.
  task automatic test_match_rounding();
    send_hit(make_hit(0, 0, 0, 0, 1, IdentHalf, 1'b1, 1, 1'b1));
    send_hit(make_hit(0, 0, 0, 0, 1, IdentHalf - 1'b1, 1'b1, 3, 1'b1));
    send_hit(make_hit(0, 0, 0, 0, 3, IdentW'(49152), 1'b0, 2, 1'b1));
    drain_scores();
  endtask

  // Plus strand: gap exactly at the threshold, short advance, gap one below.
  task automatic test_plus_strand_exons();
    send_hit(make_hit(100, 200, 1000, 1100, 100, IdentOne, 1'b1, 1000, 1'b0));
    send_hit(make_hit(230, 300, 1155, 1225, 70, IdentOne, 1'b1, 1000, 1'b0));
    send_hit(make_hit(300, 309, 1230, 2000, 9, IdentOne, 1'b1, 1000, 1'b0));
    send_hit(make_hit(305, 319, 2020, 2100, 14, IdentOne, 1'b1, 250, 1'b1));
    drain_scores();
  endtask

  // Minus strand with a mirrored gap test; the later strand flip is ignored.
  task automatic test_minus_strand_exons();
    send_hit(make_hit(0, 50, 5000, 4950, 50, IdentOne, 1'b0, 500, 1'b0));
    send_hit(make_hit(60, 120, 4915, 4850, 60, IdentOne, 1'b0, 500, 1'b0));
    send_hit(make_hit(120, 200, 4826, 4700, 80, IdentOne, 1'b1, 180, 1'b1));
    drain_scores();
  endtask

  // No wrap near the top of the coordinate range, a start past the stop,
  // and a negative implied subject start.
  task automatic test_coordinate_edges();
    send_hit(make_hit(0, 32'hFFFF_FFF8, 10, 20, 5, IdentOne, 1'b1, 100, 1'b0));
    send_hit(make_hit(32'hFFFF_FFF0, '1, 30, 40, 15, IdentOne, 1'b1, '1, 1'b1));
    send_hit(make_hit(0, 100, 50, 60, 200, IdentOne, 1'b1, 100, 1'b0));
    send_hit(make_hit(5000, 4000, 0, '1, 10, IdentOne, 1'b1, 100, 1'b0));
    send_hit(make_hit(4000, 4200, 10, 300, 200, IdentOne, 1'b1, 7, 1'b1));
    drain_scores();
  endtask

  // Both registers at zero and at full scale; writes to unused indexes change nothing.
  task automatic test_register_writes();
    write_reg(CfgMinExon, '0);
    write_reg(CfgMinIntron, '0);
    write_reg(CfgUnusedA, '1);
    write_reg(CfgUnusedB, '1);
    send_hit(make_hit(10, 20, 100, 150, 10, IdentOne, 1'b1, 100, 1'b0));
    send_hit(make_hit(20, 20, 150, 160, 0, IdentOne, 1'b1, 20, 1'b1));
    drain_scores();
    write_reg(CfgMinExon, '1);
    write_reg(CfgMinIntron, '1);
    write_reg(CfgUnusedA, '0);
    send_hit(make_hit(0, 0, 0, 32'h0001_0000, 0, IdentOne, 1'b0, 100, 1'b0));
    send_hit(make_hit(0, 32'h0000_FFFF, 1, 0, 0, IdentOne, 1'b0, 32'h0000_FFFF, 1'b1));
    drain_scores();
  endtask

  // Random compartments mixed with noise hits, over several register settings.
  task automatic test_random_compartments();
    logic [CfgW-1:0] exon_len;
    logic [CfgW-1:0] intron_len;
    int              phase_start;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0: begin exon_len = MinExonReset; intron_len = MinIntronReset; end
        1: begin exon_len = '0; intron_len = '0; end
        2: begin exon_len = '1; intron_len = '1; end
        3: begin exon_len = '0; intron_len = '1; end
        4: begin exon_len = '1; intron_len = '0; end
        default: begin
          exon_len   = ($urandom_range(0, 3) == 0) ? CfgW'($urandom())
                                                    : CfgW'($urandom_range(0, 64));
          intron_len = ($urandom_range(0, 3) == 0) ? CfgW'($urandom())
                                                    : CfgW'($urandom_range(0, 200));
        end
      endcase
      write_reg(CfgMinExon, exon_len);
      write_reg(CfgMinIntron, intron_len);
      phase_start = hits_sent;
      while (hits_sent - phase_start < PhaseItems) begin
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) send_hit(noise_hit(1'b0));
        else send_compartment();
      end
      // Close a compartment left open by noise so the phase ends idle.
      if (cmp_open) send_hit(noise_hit(1'b1));
      drain_scores();
    end
  endtask

  // Score receiver: random pop stalls, each accepted score checked against the oldest one due.
  initial begin : score_sink
    int     stall;
    score_t want;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_no_idle = ~sink_no_idle;
      stall = sink_no_idle ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if (expected_scores.size() == 0) begin
        report_mismatch($sformatf("score with no transaction pending: exon %0d match %0d bin %0d",
                                  score_o.exon_count, score_o.match_count,
                                  score_o.identity_bin));
      end else begin
        want = expected_scores.pop_front();
        if (score_o.exon_count !== want.exon_count)
          report_mismatch($sformatf("exon_count got %0d expected %0d",
                                    score_o.exon_count, want.exon_count));
        if (score_o.match_count !== want.match_count)
          report_mismatch($sformatf("match_count got %0d expected %0d",
                                    score_o.match_count, want.match_count));
        if (score_o.identity_bin !== want.identity_bin)
          report_mismatch($sformatf("identity_bin got %0d expected %0d",
                                    score_o.identity_bin, want.identity_bin));
      end
    end
  end

  // Reset, directed tests, random test, verdict.
  initial begin : test_sequence
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CfgMinExon;
    cfg_data_i = '0;
    hit_i      = '0;
    push       = 1'b0;
    cfg_min_exon   = MinExonReset;
    cfg_min_intron = MinIntronReset;
    clear_compartment();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_hit_extremes();
    test_match_rounding();
    test_plus_strand_exons();
    test_minus_strand_exons();
    test_coordinate_edges();
    test_register_writes();
    test_random_compartments();

    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
